@@ rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the swap stability monitor
// Status codes, register indexes, reset values of the configuration
// registers and the structs that run between the chain cells.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned LatW    = 30;
  localparam int unsigned WinCfgW = 9;
  localparam int unsigned PerW    = 30;
  localparam int unsigned TolW    = 30;
  localparam int unsigned StopW   = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [2:0] {
    ST_UNINIT   = 3'd0,
    ST_INSUFF   = 3'd1,
    ST_STOPPED  = 3'd2,
    ST_UNSTABLE = 3'd3,
    ST_STABLE   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LATENCY   = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_NOMINAL   = 3'd2,
    REG_TOLERANCE = 3'd3,
    REG_STOPPAGE  = 3'd4
  } cfg_idx_e;

  localparam logic [LatW-1:0]    LatencyRst   = 30'd0;
  localparam logic [WinCfgW-1:0] WindowRst    = 9'd2;
  localparam logic [PerW-1:0]    NominalRst   = 30'd16666667;
  localparam logic [TolW-1:0]    ToleranceRst = 30'd1000000;
  localparam logic [StopW-1:0]   StoppageRst  = 32'd50000000;

  // one shift step of the chain
  typedef struct packed {
    logic shift;  // a swap is being recorded this cycle
    logic good;   // the new interval is in tolerance (and not the first sample)
  } cell_ctl_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    logic held;   // at least index+1 samples held
    logic run;    // at least index+1 good intervals in a row
  } cell_link_t;

endpackage

@@ rtl/ssm_cell.sv @@
// ----------------------------------------------------------------------------
// ssm_cell: one position of the sample / interval chain
// Holds thermometer bits for samples held and for the good-interval run;
// on a recorded swap each takes the left bit, masked by window / good flag.
// ----------------------------------------------------------------------------
module ssm_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssm_pkg::cell_ctl_t  ctl_i,
  input  ssm_pkg::cell_link_t prev_i,
  input  logic [IdxW-1:0]     w_eff_i,
  output ssm_pkg::cell_link_t link_o,
  output logic                held_hit_o,
  output logic                run_hit_o
);
  import ssm_pkg::*;

  localparam logic [IdxW-1:0] IdxC   = IdxW'(Index);
  localparam logic [IdxW-1:0] IdxP1C = IdxW'(Index + 1);
  localparam logic [IdxW-1:0] IdxP2C = IdxW'(Index + 2);

  logic held_q, held_d;
  logic run_q, run_d;
  logic in_win;

  // held count clips to the window on a recorded swap
  assign in_win = (IdxC < w_eff_i);

  always_comb begin
    held_d = held_q;
    run_d  = run_q;
    if (ctl_i.shift) begin
      held_d = prev_i.held & in_win;
      run_d  = prev_i.run & ctl_i.good;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      run_q  <= 1'b0;
    end else begin
      held_q <= held_d;
      run_q  <= run_d;
    end
  end

  assign link_o.held = held_q;
  assign link_o.run  = run_q;

  // taps: held >= window, run >= window - 1
  assign held_hit_o = held_q & (IdxP1C == w_eff_i);
  assign run_hit_o  = run_q & (IdxP2C == w_eff_i);

endmodule

@@ rtl/swap_stability_monitor.sv @@
// ----------------------------------------------------------------------------
// swap_stability_monitor: buffer swap timing classifier
// Records latency-corrected swap times and classifies every item as
// insufficient data, stopped, unstable or stable, flagging status changes.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------
//  input     | in        | in_valid_i / in_ready_o | mode_i, swap_time_i, now_time_i
//  result    | out       | out_valid_o/out_ready_i | status_o, status_changed_o
//  config    | in        | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
//  One transfer per cycle sustained while out_ready_i is high; an input
//  passes the correct stage and the commit stage, then the output register
//  loads and raises out_valid_o.
//  Reset clears the chain, the last swap time and the previous status; no
//  clearing pass is needed.
//  A stalled output holds stages B and C, and A once B is full; in_ready_o
//  drops only when every stage is full and the output is not taken.
// ----------------------------------------------------------------------------
module swap_stability_monitor #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ssm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic signed [ssm_pkg::TimeW-1:0] swap_time_i,
  input  logic signed [ssm_pkg::TimeW-1:0] now_time_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic                          status_changed_o
);
  import ssm_pkg::*;

  // window arithmetic width: holds MAX_WINDOW + 2 and the raw 9-bit register
  localparam int unsigned WinW =
    ($clog2(MAX_WINDOW + 2) + 1 > 10) ? $clog2(MAX_WINDOW + 2) + 1 : 10;
  localparam logic [WinW-1:0] MaxWinC = WinW'(MAX_WINDOW);
  localparam logic [WinW-1:0] MinWinC = WinW'(2);
  localparam int unsigned DiffW = TimeW + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [LatW-1:0]    lat_q;
  logic [WinCfgW-1:0] win_q;
  logic [PerW-1:0]    nom_q;
  logic [TolW-1:0]    tol_q;
  logic [StopW-1:0]   stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q  <= LatencyRst;
      win_q  <= WindowRst;
      nom_q  <= NominalRst;
      tol_q  <= ToleranceRst;
      stop_q <= StoppageRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LATENCY:   lat_q  <= cfg_wdata_i[LatW-1:0];
        REG_WINDOW:    win_q  <= cfg_wdata_i[WinCfgW-1:0];
        REG_NOMINAL:   nom_q  <= cfg_wdata_i[PerW-1:0];
        REG_TOLERANCE: tol_q  <= cfg_wdata_i[TolW-1:0];
        REG_STOPPAGE:  stop_q <= cfg_wdata_i[StopW-1:0];
        default: ;
      endcase
    end
  end

  // tolerance band (nominal - tol, nominal + tol), refreshed every cycle;
  // config changes must come only while idle (the block does not enforce it), so band lag is harmless
  logic signed [PerW:0] band_lo_q;
  logic        [PerW:0] band_hi_q;

  always_ff @(posedge clk_i) begin
    band_lo_q <= $signed({1'b0, nom_q}) - $signed({1'b0, tol_q});
    band_hi_q <= {1'b0, nom_q} + {1'b0, tol_q};
  end

  // effective window, clamped to [2, MAX_WINDOW]
  logic [WinW-1:0] w_raw, w_eff;
  assign w_raw = WinW'(win_q);
  always_comb begin
    w_eff = w_raw;
    if (w_raw < MinWinC) begin
      w_eff = MinWinC;
    end else if (w_raw > MaxWinC) begin
      w_eff = MaxWinC;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: A = corrected time, B = committed, C = output register
  // --------------------------------------------------------------------------
  logic a_v_q, b_v_q, c_v_q;
  logic a_adv, b_adv;

  assign b_adv      = !c_v_q || out_ready_i;
  assign a_adv      = !b_v_q || b_adv;
  assign in_ready_o = !a_v_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (in_ready_o) a_v_q <= in_valid_i;
      if (a_adv)      b_v_q <= a_v_q;
      if (b_adv)      c_v_q <= b_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage A: subtract latency, saturate low to the 48-bit range
  // --------------------------------------------------------------------------
  logic signed [DiffW-1:0] corr_full;
  logic signed [TimeW-1:0] corr_time;
  logic                    a_mode_q;
  logic signed [TimeW-1:0] a_time_q, a_now_q;

  assign corr_full = $signed({swap_time_i[TimeW-1], swap_time_i})
                   - $signed({{(DiffW - LatW){1'b0}}, lat_q});
  // only underflow is possible: latency is never negative
  assign corr_time = (corr_full[DiffW-1] && !corr_full[DiffW-2])
                   ? {1'b1, {(TimeW - 1){1'b0}}}
                   : corr_full[TimeW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_mode_q <= mode_i;
      a_time_q <= corr_time;
      a_now_q  <= now_time_i;
    end
  end

  // --------------------------------------------------------------------------
  // commit A -> B: interval check, shift the chain, update last swap time
  // --------------------------------------------------------------------------
  logic signed [TimeW-1:0] last_q;
  logic signed [DiffW-1:0] ivl;
  logic                    ivl_good;
  logic                    commit;
  cell_ctl_t               ctl;
  logic                    any_held;

  assign commit = a_v_q && a_adv && !a_mode_q;

  assign ivl = $signed({a_time_q[TimeW-1], a_time_q})
             - $signed({last_q[TimeW-1], last_q});
  assign ivl_good = (ivl > DiffW'(band_lo_q))
                 && (ivl < $signed({{(DiffW - PerW - 1){1'b0}}, band_hi_q}));

  // first sample has no interval: the run restarts at zero
  assign ctl.shift = commit;
  assign ctl.good  = ivl_good && any_held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (commit) begin
      last_q <= a_time_q;
    end
  end

  // chain of cells: cell k says "held > k" and "run > k"
  cell_link_t            links [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] held_hits, run_hits;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    cell_link_t prev;
    if (k == 0) begin : g_head
      assign prev.held = 1'b1;
      assign prev.run  = 1'b1;
    end else begin : g_body
      assign prev = links[k-1];
    end
    ssm_cell #(
      .Index (k),
      .IdxW  (WinW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .prev_i     (prev),
      .w_eff_i    (w_eff),
      .link_o     (links[k]),
      .held_hit_o (held_hits[k]),
      .run_hit_o  (run_hits[k])
    );
  end

  assign any_held = links[0].held;

  logic signed [TimeW-1:0] b_now_q;
  always_ff @(posedge clk_i) begin
    if (a_adv && a_v_q) begin
      b_now_q <= a_now_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage B: classify against the committed state (held still while B stalls)
  // --------------------------------------------------------------------------
  logic signed [DiffW-1:0] since_last;
  logic                    stopped, enough, steady;
  status_e                 st, prev_q;

  assign since_last = $signed({b_now_q[TimeW-1], b_now_q})
                    - $signed({last_q[TimeW-1], last_q});
  assign stopped = since_last > $signed({{(DiffW - StopW){1'b0}}, stop_q});
  assign enough  = |held_hits;
  assign steady  = |run_hits;

  always_comb begin
    priority if (!any_held) begin
      st = ST_INSUFF;
    end else if (stopped) begin
      st = ST_STOPPED;
    end else if (!enough) begin
      st = ST_INSUFF;
    end else if (!steady) begin
      st = ST_UNSTABLE;
    end else begin
      st = ST_STABLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= ST_UNINIT;
    end else if (b_v_q && b_adv) begin
      prev_q <= st;
    end
  end

  // --------------------------------------------------------------------------
  // stage C: output register
  // --------------------------------------------------------------------------
  status_e c_status_q;
  logic    c_chg_q;

  always_ff @(posedge clk_i) begin
    if (b_v_q && b_adv) begin
      c_status_q <= st;
      c_chg_q    <= (st != prev_q);
    end
  end

  assign out_valid_o      = c_v_q;
  assign status_o         = c_status_q;
  assign status_changed_o = c_chg_q;

endmodule
